// ===== design/psv_pkg.sv =====
// ----------------------------------------------------------------------------
// psv_pkg
// Shared types, codes and constants of the plucked-string voice.
// ----------------------------------------------------------------------------
`default_nettype none

package psv_pkg;

	localparam int TABLE_DEPTH = 4096;

	localparam int SAMPLE_W  = 16;
	localparam int VEL_W     = 7;
	localparam int VOL_W     = 7;
	localparam int LEN_W     = 13;
	localparam int REL_W     = 20;
	localparam int NUM_W     = REL_W + 1;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = REL_W;

	// operation codes
	localparam logic [1:0] OP_TICK     = 2'd0;
	localparam logic [1:0] OP_NOTE_ON  = 2'd1;
	localparam logic [1:0] OP_NOTE_OFF = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VOLUME  = 2'd2;

	localparam logic [REL_W-1:0] RELEASE_RESET = 20'd480;
	localparam logic [VOL_W-1:0] VOLUME_RESET  = 7'd75;

	localparam logic [31:0] LFSR_MASK = 32'h8020_0003;
	localparam logic [31:0] LFSR_SEED = 32'h0000_0001;

	// full-scale gain divisor: velocity 127 times volume 100
	localparam int          GAIN_DIV_W = 14;
	localparam logic [GAIN_DIV_W-1:0] GAIN_DIV = 14'd12700;

	typedef struct packed {
		logic [1:0]       operation;
		logic [VEL_W-1:0] velocity;
		logic [LEN_W-1:0] string_length;
	} psv_in_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       voice_active;
	} psv_out_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] v;
		logic [VEL_W-1:0]           velocity;
		logic [VOL_W-1:0]           volume;
		logic [NUM_W-1:0]           num;
		logic [NUM_W-1:0]           den;
	} psv_gain_req_t;

endpackage

`default_nettype wire

// ===== design/psv_ram.sv =====
// ----------------------------------------------------------------------------
// psv_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module psv_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== design/psv_gain.sv =====
// ----------------------------------------------------------------------------
// psv_gain
// Output scaling: |v| * velocity * volume * num / (12700 * den), rounded half
// away from zero and saturated to Q1.15. Multiplies in three steps, then a
// restoring divider produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module psv_gain (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire psv_pkg::psv_gain_req_t  req,
	output logic                         done,
	output logic signed [psv_pkg::SAMPLE_W-1:0] sample
);

	localparam int MAG_W = psv_pkg::SAMPLE_W;
	localparam int P1_W  = MAG_W + psv_pkg::VEL_W;
	localparam int P2_W  = P1_W + psv_pkg::VOL_W;
	localparam int P3_W  = P2_W + psv_pkg::NUM_W;
	localparam int D_W   = psv_pkg::NUM_W + psv_pkg::GAIN_DIV_W;
	localparam int N_W   = P3_W + 1;
	localparam int QB    = N_W - D_W;
	localparam int CNT_W = $clog2(QB);

	localparam logic [2:0] G_IDLE = 3'd0;
	localparam logic [2:0] G_MUL1 = 3'd1;
	localparam logic [2:0] G_MUL2 = 3'd2;
	localparam logic [2:0] G_MUL3 = 3'd3;
	localparam logic [2:0] G_PREP = 3'd4;
	localparam logic [2:0] G_DIV  = 3'd5;
	localparam logic [2:0] G_SAT  = 3'd6;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;

	logic                    neg_q;
	logic [MAG_W-1:0]        mag_q;
	logic [psv_pkg::VEL_W-1:0] vel_q;
	logic [psv_pkg::VOL_W-1:0] vol_q;
	logic [psv_pkg::NUM_W-1:0] num_q;
	logic [psv_pkg::NUM_W-1:0] den_q;
	logic [P1_W-1:0]         p1_q;
	logic [D_W-1:0]          d_q;
	logic [P2_W-1:0]         p2_q;
	logic [P3_W-1:0]         p3_q;
	logic [D_W-1:0]          rem_q;
	logic [QB-1:0]           quo_q;
	logic signed [psv_pkg::SAMPLE_W-1:0] sample_q;

	logic [N_W-1:0] dividend;
	logic [D_W:0]   trial;
	logic           ge;
	logic [QB-1:0]  quo_neg;

	assign dividend = N_W'(p3_q) + N_W'(d_q >> 1);
	assign trial    = {rem_q, quo_q[QB-1]};
	assign ge       = (trial >= {1'b0, d_q});
	assign quo_neg  = ~quo_q + QB'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				G_IDLE: begin
					if (start) begin
						state_q <= G_MUL1;
					end
				end
				G_MUL1: state_q <= G_MUL2;
				G_MUL2: state_q <= G_MUL3;
				G_MUL3: state_q <= G_PREP;
				G_PREP: begin
					cnt_q   <= '0;
					state_q <= G_DIV;
				end
				G_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(QB - 1)) begin
						state_q <= G_SAT;
					end
				end
				G_SAT: begin
					done_q  <= 1'b1;
					state_q <= G_IDLE;
				end
				default: state_q <= G_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			G_IDLE: begin
				neg_q <= req.v[psv_pkg::SAMPLE_W-1];
				mag_q <= req.v[psv_pkg::SAMPLE_W-1] ? (~req.v + MAG_W'(1)) : req.v;
				vel_q <= req.velocity;
				vol_q <= req.volume;
				num_q <= req.num;
				den_q <= req.den;
			end
			G_MUL1: begin
				p1_q <= P1_W'(mag_q) * P1_W'(vel_q);
				d_q  <= D_W'(den_q) * D_W'(psv_pkg::GAIN_DIV);
			end
			G_MUL2: p2_q <= P2_W'(p1_q) * P2_W'(vol_q);
			G_MUL3: p3_q <= P3_W'(p2_q) * P3_W'(num_q);
			G_PREP: begin
				rem_q <= dividend[N_W-1:QB];
				quo_q <= dividend[QB-1:0];
			end
			G_DIV: begin
				rem_q <= ge ? D_W'(trial - {1'b0, d_q}) : trial[D_W-1:0];
				quo_q <= {quo_q[QB-2:0], ge};
			end
			G_SAT: begin
				if (neg_q) begin
					sample_q <= (quo_q > QB'(32768)) ? 16'sh8000 : $signed(quo_neg[15:0]);
				end else begin
					sample_q <= (quo_q > QB'(32767)) ? 16'sh7FFF : $signed(quo_q[15:0]);
				end
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign sample = sample_q;

endmodule

`default_nettype wire

// ===== design/plucked_string_voice_unit.sv =====
// ----------------------------------------------------------------------------
// plucked_string_voice_unit
// One plucked-string voice: note-on, note-off and sample-tick words in,
// one saturated Q1.15 sample word out per tick.
// ----------------------------------------------------------------------------
// One item is handled at a time. Note-on, note-off and unknown words are taken
// in the idle state. A tick of an idle or just-stopped voice goes from the tick
// state straight to output; a sounding tick is paced by the gain unit: three
// multiply steps and a restoring divider that yields one of 17 quotient bits
// per cycle. The string table sits in one RAM with a registered read; an
// averaging tick reads it twice and writes once. The table needs no clearing
// after reset, since every note's first pass writes entries before they are
// read. The result is held in an output register, so a stalled result holds
// up the next tick's result, and all input while that tick waits.
// ----------------------------------------------------------------------------
`default_nettype none

module plucked_string_voice_unit #(
	parameter int TABLE_DEPTH = psv_pkg::TABLE_DEPTH
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire psv_pkg::psv_in_t                  in_data,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output psv_pkg::psv_out_t                      out_data,
	input  wire logic                              cfg_we,
	input  wire logic [psv_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [psv_pkg::CFG_W-1:0]         cfg_data
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int LW = $clog2(TABLE_DEPTH + 1);
	localparam int NW = psv_pkg::NUM_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_TICK  = 3'd1;
	localparam logic [2:0] ST_RD1   = 3'd2;
	localparam logic [2:0] ST_RD2   = 3'd3;
	localparam logic [2:0] ST_SCALE = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0]                  state_q;
	logic                        sustain_q;
	logic [psv_pkg::REL_W-1:0]   release_q;
	logic [psv_pkg::VOL_W-1:0]   volume_q;
	logic                        voice_on_q;
	logic                        released_q;
	logic [psv_pkg::VEL_W-1:0]   vel_q;
	logic [LW-1:0]               len_q;
	logic [31:0]                 tson_q;
	logic [31:0]                 tsoff_q;
	logic [31:0]                 lfsr_q;
	logic [AW-1:0]               idx_q;
	logic [NW-1:0]               num_q;
	logic [NW-1:0]               den_q;
	logic signed [15:0]          a_q;
	psv_pkg::psv_out_t           res_q;
	logic                        out_valid_q;
	psv_pkg::psv_out_t           out_data_q;

	logic                        in_acc;
	logic [31:0]                 len_in;
	logic [31:0]                 len_clamp;
	logic                        s_lt;
	logic                        s_eq;
	logic [AW-1:0]               prev_idx;
	logic [LW-1:0]               idx_inc;
	logic [31:0]                 lfsr_next;
	logic [NW-1:0]               rel_r;
	logic                        releasing;
	logic                        stop;
	logic [NW-1:0]               rel_num;
	logic [NW-1:0]               rel_den;
	logic signed [15:0]          rd_val;
	logic [16:0]                 sum17;
	logic signed [15:0]          avg;
	logic                        can_load;

	logic                        ram_we;
	logic [15:0]                 ram_wdata;
	logic [AW-1:0]               ram_raddr;
	logic [15:0]                 ram_rdata;

	logic                        gain_start;
	logic signed [15:0]          v_now;
	psv_pkg::psv_gain_req_t      gain_req;
	logic                        gain_done;
	logic signed [15:0]          gain_sample;

	assign in_acc   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign can_load = !out_valid_q || !out_stall;

	assign len_in    = 32'(in_data.string_length);
	assign len_clamp = (len_in < 32'd2) ? 32'd2 :
	                   (len_in > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : len_in;

	assign s_lt     = tson_q < 32'(len_q);
	assign s_eq     = tson_q == 32'(len_q);
	assign prev_idx = (idx_q == '0) ? AW'(len_q - LW'(1)) : idx_q - AW'(1);
	assign idx_inc  = LW'(idx_q) + LW'(1);

	assign lfsr_next = {1'b0, lfsr_q[31:1]} ^ (lfsr_q[0] ? psv_pkg::LFSR_MASK : 32'd0);

	assign rel_r     = NW'(release_q) + NW'(1);
	assign releasing = released_q && !sustain_q && (tsoff_q != 32'd0);
	assign stop      = releasing && (tsoff_q > 32'(rel_r));
	assign rel_num   = releasing ? (rel_r - tsoff_q[NW-1:0]) : NW'(1);
	assign rel_den   = releasing ? rel_r : NW'(1);

	assign rd_val = $signed(ram_rdata);
	assign sum17  = {a_q[15], a_q} + {rd_val[15], rd_val};
	assign avg    = $signed(sum17[16:1]);

	assign ram_raddr = (state_q == ST_RD1) ? prev_idx : idx_q;

	always_comb begin
		gain_start = 1'b0;
		v_now      = rd_val;
		ram_we     = 1'b0;
		ram_wdata  = lfsr_next[15:0];
		case (state_q)
			ST_TICK: begin
				if (voice_on_q && !stop && s_lt) begin
					gain_start = 1'b1;
					v_now      = $signed(lfsr_next[15:0]);
					ram_we     = 1'b1;
				end
			end
			ST_RD1: begin
				gain_start = s_eq;
			end
			ST_RD2: begin
				gain_start = 1'b1;
				v_now      = avg;
				ram_we     = 1'b1;
				ram_wdata  = avg;
			end
			default: ;
		endcase
	end

	always_comb begin
		gain_req.v        = v_now;
		gain_req.velocity = vel_q;
		gain_req.volume   = volume_q;
		gain_req.num      = (state_q == ST_TICK) ? rel_num : num_q;
		gain_req.den      = (state_q == ST_TICK) ? rel_den : den_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sustain_q   <= 1'b0;
			release_q   <= psv_pkg::RELEASE_RESET;
			volume_q    <= psv_pkg::VOLUME_RESET;
			voice_on_q  <= 1'b0;
			released_q  <= 1'b0;
			vel_q       <= '0;
			len_q       <= LW'(2);
			tson_q      <= '0;
			tsoff_q     <= '0;
			lfsr_q      <= psv_pkg::LFSR_SEED;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					psv_pkg::CFG_SUSTAIN: sustain_q <= cfg_data[0];
					psv_pkg::CFG_RELEASE: release_q <= cfg_data;
					psv_pkg::CFG_VOLUME:  volume_q  <= cfg_data[psv_pkg::VOL_W-1:0];
					default: ;
				endcase
			end

			if ((state_q == ST_OUT) && can_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (gain_start) begin
				tson_q <= tson_q + 32'd1;
				if (tson_q == 32'hFFFF_FFFF) begin
					idx_q <= '0;
				end else if (idx_inc == len_q) begin
					idx_q <= '0;
				end else begin
					idx_q <= AW'(idx_inc);
				end
				if (released_q && (tsoff_q != 32'hFFFF_FFFF)) begin
					tsoff_q <= tsoff_q + 32'd1;
				end
				if (state_q == ST_TICK) begin
					lfsr_q <= lfsr_next;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (in_data.operation)
							psv_pkg::OP_TICK: state_q <= ST_TICK;
							psv_pkg::OP_NOTE_ON: begin
								released_q <= (in_data.velocity == '0);
								tsoff_q    <= '0;
								if (in_data.velocity != '0) begin
									voice_on_q <= 1'b1;
									tson_q     <= '0;
									idx_q      <= '0;
									vel_q      <= in_data.velocity;
									len_q      <= LW'(len_clamp);
								end
							end
							psv_pkg::OP_NOTE_OFF: begin
								released_q <= 1'b1;
								tsoff_q    <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_TICK: begin
					if (!voice_on_q) begin
						state_q <= ST_OUT;
					end else if (stop) begin
						voice_on_q <= 1'b0;
						state_q    <= ST_OUT;
					end else if (s_lt) begin
						state_q <= ST_SCALE;
					end else begin
						state_q <= ST_RD1;
					end
				end
				ST_RD1: state_q <= s_eq ? ST_SCALE : ST_RD2;
				ST_RD2: state_q <= ST_SCALE;
				ST_SCALE: begin
					if (gain_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (can_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_TICK) begin
			num_q                <= rel_num;
			den_q                <= rel_den;
			res_q.sample         <= '0;
			res_q.voice_active   <= 1'b0;
		end
		if (state_q == ST_RD1) begin
			a_q <= rd_val;
		end
		if ((state_q == ST_SCALE) && gain_done) begin
			res_q.sample       <= gain_sample;
			res_q.voice_active <= 1'b1;
		end
		if ((state_q == ST_OUT) && can_load) begin
			out_data_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	psv_ram #(
		.WIDTH(16),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	psv_gain u_gain (
		.clk   (clk),
		.arst_n(arst_n),
		.start (gain_start),
		.req   (gain_req),
		.done  (gain_done),
		.sample(gain_sample)
	);

endmodule

`default_nettype wire
